@@ design/gpio_controller_edge_detect_core_macros.svh @@
// ----------------------------------------------------------------------------
// GPIO edge detect core assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef GPIO_CONTROLLER_EDGE_DETECT_CORE_MACROS_SVH
`define GPIO_CONTROLLER_EDGE_DETECT_CORE_MACROS_SVH

// Assertion disabled while rst_n is low.
`define GPIO_ED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define GPIO_ED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/gpio_ed_pkg.sv @@
// ----------------------------------------------------------------------------
// GPIO edge detect package
// Operation codes, register word offsets and field widths.
// ----------------------------------------------------------------------------
package gpio_ed_pkg;

  localparam int DEFAULT_NUM_PINS = 58;

  localparam int OP_W     = 2;
  localparam int WORD_W   = 6;
  localparam int DATA_W   = 32;
  localparam int PADS_W   = 58;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 152;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [WORD_W-1:0] W_FSEL0  = 6'd0;
  localparam logic [WORD_W-1:0] W_FSEL5  = 6'd5;
  localparam logic [WORD_W-1:0] W_SET0   = 6'd7;
  localparam logic [WORD_W-1:0] W_SET1   = 6'd8;
  localparam logic [WORD_W-1:0] W_CLR0   = 6'd10;
  localparam logic [WORD_W-1:0] W_CLR1   = 6'd11;
  localparam logic [WORD_W-1:0] W_LEV0   = 6'd13;
  localparam logic [WORD_W-1:0] W_LEV1   = 6'd14;
  localparam logic [WORD_W-1:0] W_EDS0   = 6'd16;
  localparam logic [WORD_W-1:0] W_EDS1   = 6'd17;
  localparam logic [WORD_W-1:0] W_REN0   = 6'd19;
  localparam logic [WORD_W-1:0] W_REN1   = 6'd20;
  localparam logic [WORD_W-1:0] W_FEN0   = 6'd22;
  localparam logic [WORD_W-1:0] W_FEN1   = 6'd23;
  localparam logic [WORD_W-1:0] W_PULL0  = 6'd57;
  localparam logic [WORD_W-1:0] W_PULL3  = 6'd60;

  localparam int FSEL_PER_WORD = 10;
  localparam int PULL_PER_WORD = 16;
  localparam int MAX_FSEL_PINS = 60;
  localparam logic [2:0] FSEL_OUT = 3'd1;

endpackage

@@ design/gpio_controller_edge_detect_core.sv @@
// ----------------------------------------------------------------------------
// GPIO controller with edge event detection
// Register-mapped GPIO with function select, set/clear latch, edge events.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one transfer per bus read, bus write or pad sample
// tick; in_tuser holds the operation. Every accepted transfer produces exactly
// one transfer on the out_ channel, in order, carrying the read data (zero for
// anything but a read), the output latch, the output enables and the
// interrupt flag, all as they stand after that item has taken effect.
// An accepted item is held in the input register while the update logic
// works on it, and is then loaded into the result register. One item is
// accepted every cycle while the result register advances; the throughput
// limit is the single result register, which advances whenever it is empty
// or being taken.
// When the receiver holds out_tready low the result waits in the output
// register, the input register still takes one more transfer, and then
// in_tready drops until the result is taken.
// Reset clears all pin state (function select to input, latch, enables,
// event status, sampled levels, pull control) and empties both stages.
// ----------------------------------------------------------------------------
`include "gpio_controller_edge_detect_core_macros.svh"

module gpio_controller_edge_detect_core #(
  parameter int NUM_PINS = gpio_ed_pkg::DEFAULT_NUM_PINS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // reg_word [5:0], write_data [37:6], pad_levels [95:38]
  input  logic [gpio_ed_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation [1:0]
  input  logic [gpio_ed_pkg::OP_W-1:0]         in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_data [31:0], drive_levels [89:32], drive_enables [147:90],
  // event_pending [148], zero [151:149]
  output logic [gpio_ed_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import gpio_ed_pkg::*;

  localparam int NUM_FSEL = (NUM_PINS < MAX_FSEL_PINS) ? NUM_PINS : MAX_FSEL_PINS;

  // Input register stage.
  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [WORD_W-1:0]   s1_word_r;
  logic [DATA_W-1:0]   s1_data_r;
  logic [PADS_W-1:0]   s1_pads_r;

  // Architectural pin state, one bit (or field) per pin.
  logic [2:0]          fsel_r [NUM_FSEL];
  logic [1:0]          pull_r [NUM_PINS];
  logic [NUM_PINS-1:0] latch_r;
  logic [NUM_PINS-1:0] ren_r;
  logic [NUM_PINS-1:0] fen_r;
  logic [NUM_PINS-1:0] evt_r;
  logic [NUM_PINS-1:0] prev_r;

  logic [2:0]          fsel_nxt [NUM_FSEL];
  logic [1:0]          pull_nxt [NUM_PINS];
  logic [NUM_PINS-1:0] latch_nxt;
  logic [NUM_PINS-1:0] ren_nxt;
  logic [NUM_PINS-1:0] fen_nxt;
  logic [NUM_PINS-1:0] evt_nxt;
  logic [NUM_PINS-1:0] prev_nxt;

  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                fire;
  logic                tick_fire;
  logic                write_fire;
  logic [DATA_W-1:0]   rd_word;
  logic [DATA_W-1:0]   rd_result;
  logic [63:0]         en64;
  logic [63:0]         latch64;

  // Return one 32-bit half of a 64-bit view of a pin vector.
  function automatic logic [31:0] half_get(input logic [63:0] v, input logic hi);
    return hi ? v[63:32] : v[31:0];
  endfunction

  // Replace one 32-bit half of a 64-bit view with write data.
  function automatic logic [63:0] half_put(input logic [63:0] v, input logic hi,
                                           input logic [31:0] d);
    return hi ? {d, v[31:0]} : {v[63:32], d};
  endfunction

  // The result stage advances when it is empty or its transfer completes.
  assign fire       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || fire;
  assign tick_fire  = fire && (s1_op_r == OP_TICK);
  assign write_fire = fire && (s1_op_r == OP_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_word_r <= in_tdata[5:0];
      s1_data_r <= in_tdata[37:6];
      s1_pads_r <= in_tdata[95:38];
    end
  end

  // Read multiplexer over the current state.
  always_comb begin
    rd_word = '0;
    unique case (s1_word_r) inside
      [W_FSEL0:W_FSEL5]: begin
        for (int p = 0; p < NUM_FSEL; p++) begin
          if (int'(s1_word_r) == p / FSEL_PER_WORD) begin
            rd_word[3*(p % FSEL_PER_WORD) +: 3] = fsel_r[p];
          end
        end
      end
      [W_PULL0:W_PULL3]: begin
        for (int p = 0; p < NUM_PINS; p++) begin
          if (int'(s1_word_r) == int'(W_PULL0) + p / PULL_PER_WORD) begin
            rd_word[2*(p % PULL_PER_WORD) +: 2] = pull_r[p];
          end
        end
      end
      W_LEV0, W_LEV1: rd_word = half_get(64'(prev_r), s1_word_r == W_LEV1);
      W_EDS0, W_EDS1: rd_word = half_get(64'(evt_r), s1_word_r == W_EDS1);
      W_REN0, W_REN1: rd_word = half_get(64'(ren_r), s1_word_r == W_REN1);
      W_FEN0, W_FEN1: rd_word = half_get(64'(fen_r), s1_word_r == W_FEN1);
      default:        rd_word = '0;
    endcase
  end

  // Next-state logic for writes and sample ticks.
  always_comb begin
    logic [63:0] bits;
    logic [63:0] lv64;
    logic [NUM_PINS-1:0] lv;
    fsel_nxt  = fsel_r;
    pull_nxt  = pull_r;
    latch_nxt = latch_r;
    ren_nxt   = ren_r;
    fen_nxt   = fen_r;
    evt_nxt   = evt_r;
    prev_nxt  = prev_r;
    bits      = '0;
    lv64      = 64'(s1_pads_r);
    lv        = lv64[NUM_PINS-1:0];
    rd_result = '0;

    case (s1_op_r)
      OP_READ: begin
        rd_result = rd_word;
      end
      OP_WRITE: begin
        unique case (s1_word_r) inside
          [W_FSEL0:W_FSEL5]: begin
            for (int p = 0; p < NUM_FSEL; p++) begin
              if (int'(s1_word_r) == p / FSEL_PER_WORD) begin
                fsel_nxt[p] = s1_data_r[3*(p % FSEL_PER_WORD) +: 3];
              end
            end
          end
          [W_PULL0:W_PULL3]: begin
            for (int p = 0; p < NUM_PINS; p++) begin
              if (int'(s1_word_r) == int'(W_PULL0) + p / PULL_PER_WORD) begin
                pull_nxt[p] = s1_data_r[2*(p % PULL_PER_WORD) +: 2];
              end
            end
          end
          W_SET0, W_SET1: begin
            bits      = half_put('0, s1_word_r == W_SET1, s1_data_r);
            latch_nxt = latch_r | bits[NUM_PINS-1:0];
          end
          W_CLR0, W_CLR1: begin
            bits      = half_put('0, s1_word_r == W_CLR1, s1_data_r);
            latch_nxt = latch_r & ~bits[NUM_PINS-1:0];
          end
          W_EDS0, W_EDS1: begin
            bits    = half_put('0, s1_word_r == W_EDS1, s1_data_r);
            evt_nxt = evt_r & ~bits[NUM_PINS-1:0];
          end
          W_REN0, W_REN1: begin
            bits    = half_put(64'(ren_r), s1_word_r == W_REN1, s1_data_r);
            ren_nxt = bits[NUM_PINS-1:0];
          end
          W_FEN0, W_FEN1: begin
            bits    = half_put(64'(fen_r), s1_word_r == W_FEN1, s1_data_r);
            fen_nxt = bits[NUM_PINS-1:0];
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        evt_nxt  = evt_r | (lv & ~prev_r & ren_r) | (~lv & prev_r & fen_r);
        prev_nxt = lv;
      end
      default: begin
      end
    endcase
  end

  // Output enables follow the updated function select.
  always_comb begin
    en64 = '0;
    for (int p = 0; p < NUM_FSEL; p++) begin
      en64[p] = (fsel_nxt[p] == FSEL_OUT);
    end
  end

  assign latch64 = 64'(latch_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_FSEL; p++) begin
        fsel_r[p] <= '0;
      end
      for (int p = 0; p < NUM_PINS; p++) begin
        pull_r[p] <= '0;
      end
      latch_r <= '0;
      ren_r   <= '0;
      fen_r   <= '0;
      evt_r   <= '0;
      prev_r  <= '0;
    end else if (fire) begin
      fsel_r  <= fsel_nxt;
      pull_r  <= pull_nxt;
      latch_r <= latch_nxt;
      ren_r   <= ren_nxt;
      fen_r   <= fen_nxt;
      evt_r   <= evt_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {3'b000, |evt_nxt, en64[PADS_W-1:0], latch64[PADS_W-1:0], rd_result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `GPIO_ED_ASSERT(a_evt_set_only_on_tick, !tick_fire |=> ((evt_r & ~$past(evt_r)) == '0), "event status set without a sample tick")
  `GPIO_ED_ASSERT(a_prev_only_on_tick, !tick_fire |=> $stable(prev_r), "sampled levels changed without a sample tick")
  `GPIO_ED_ASSERT(a_latch_only_on_write, !write_fire |=> $stable(latch_r), "output latch changed without a register write")
  `GPIO_ED_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not empty after reset")

endmodule

@@ sim/gpio_ed_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO edge detect result checker
// Watches both stream channels of the core, keeps its own copy of the pin
// registers, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module gpio_ed_checker #(
  parameter int NUM_PINS = gpio_ed_pkg::DEFAULT_NUM_PINS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [gpio_ed_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [gpio_ed_pkg::OP_W-1:0]        in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [gpio_ed_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int unsigned                         mismatch_count,
  output int unsigned                         results_due
);
  import gpio_ed_pkg::*;

  localparam logic [63:0] PIN_MASK = {64{1'b1}} >> (64 - NUM_PINS);
  localparam int DATA_LSB = WORD_W;
  localparam int PADS_LSB = WORD_W + DATA_W;
  localparam int LEV_LSB  = DATA_W;
  localparam int EN_LSB   = DATA_W + PADS_W;
  localparam int EP_BIT   = DATA_W + 2 * PADS_W;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [PADS_W-1:0] drive_levels;
    logic [PADS_W-1:0] drive_enables;
    logic              event_pending;
  } gpio_result_t;

  logic [2:0]  pin_function [64];
  logic [1:0]  pin_pull [64];
  logic [63:0] latch_q;
  logic [63:0] rise_en_q;
  logic [63:0] fall_en_q;
  logic [63:0] event_q;
  logic [63:0] levels_q;

  gpio_result_t expected_results [$];
  int unsigned  fail_tally = 0;
  int unsigned  due_q = 0;

  assign mismatch_count = fail_tally;
  assign results_due    = due_q;

  function automatic logic [31:0] word_half(logic [63:0] v, bit upper);
    return upper ? v[63:32] : v[31:0];
  endfunction

  // Bits that a 32-bit write covers, placed in the lower or upper pin bank.
  function automatic logic [63:0] half_bits(logic [31:0] d, bit upper);
    return (upper ? {d, 32'h0} : {32'h0, d}) & PIN_MASK;
  endfunction

  function automatic logic [31:0] register_read(logic [WORD_W-1:0] w);
    logic [31:0] r;
    int pin;
    r = '0;
    if (w <= W_FSEL5) begin
      for (int k = 0; k < FSEL_PER_WORD; k++) begin
        pin = w * FSEL_PER_WORD + k;
        if (pin < NUM_PINS) r[3*k +: 3] = pin_function[pin];
      end
    end else if (w >= W_PULL0 && w <= W_PULL3) begin
      for (int k = 0; k < PULL_PER_WORD; k++) begin
        pin = (w - W_PULL0) * PULL_PER_WORD + k;
        if (pin < NUM_PINS) r[2*k +: 2] = pin_pull[pin];
      end
    end else begin
      case (w)
        W_LEV0, W_LEV1: r = word_half(levels_q, w == W_LEV1);
        W_EDS0, W_EDS1: r = word_half(event_q, w == W_EDS1);
        W_REN0, W_REN1: r = word_half(rise_en_q, w == W_REN1);
        W_FEN0, W_FEN1: r = word_half(fall_en_q, w == W_FEN1);
        default:        r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic void register_write(logic [WORD_W-1:0] w, logic [31:0] d);
    int pin;
    bit upper;
    if (w <= W_FSEL5) begin
      for (int k = 0; k < FSEL_PER_WORD; k++) begin
        pin = w * FSEL_PER_WORD + k;
        if (pin < NUM_PINS) pin_function[pin] = d[3*k +: 3];
      end
    end else if (w >= W_PULL0 && w <= W_PULL3) begin
      for (int k = 0; k < PULL_PER_WORD; k++) begin
        pin = (w - W_PULL0) * PULL_PER_WORD + k;
        if (pin < NUM_PINS) pin_pull[pin] = d[2*k +: 2];
      end
    end else begin
      upper = (w == W_SET1) || (w == W_CLR1) || (w == W_EDS1) ||
              (w == W_REN1) || (w == W_FEN1);
      case (w)
        W_SET0, W_SET1: latch_q = (latch_q | half_bits(d, upper)) & PIN_MASK;
        W_CLR0, W_CLR1: latch_q = latch_q & ~half_bits(d, upper);
        W_EDS0, W_EDS1: event_q = event_q & ~half_bits(d, upper);
        W_REN0, W_REN1:
          rise_en_q = (rise_en_q & ~half_bits('1, upper)) | half_bits(d, upper);
        W_FEN0, W_FEN1:
          fall_en_q = (fall_en_q & ~half_bits('1, upper)) | half_bits(d, upper);
        default: ;
      endcase
    end
  endfunction

  // Applies one item to the shadow registers and returns the result that
  // the core must give once that item has taken effect.
  function automatic gpio_result_t predict_result(logic [OP_W-1:0] op,
      logic [WORD_W-1:0] w, logic [DATA_W-1:0] d, logic [PADS_W-1:0] pads);
    gpio_result_t res;
    logic [63:0] lv;
    logic [63:0] en;
    res = '0;
    en  = '0;
    case (op)
      OP_READ:  res.read_data = register_read(w);
      OP_WRITE: register_write(w, d);
      OP_TICK: begin
        lv = 64'(pads) & PIN_MASK;
        event_q = (event_q | (lv & ~levels_q & rise_en_q) |
                   (~lv & levels_q & fall_en_q)) & PIN_MASK;
        levels_q = lv;
      end
      default: ;
    endcase
    for (int pin = 0; pin < MAX_FSEL_PINS && pin < NUM_PINS; pin++)
      if (pin_function[pin] == FSEL_OUT) en[pin] = 1'b1;
    res.drive_levels  = latch_q[PADS_W-1:0];
    res.drive_enables = en[PADS_W-1:0];
    res.event_pending = (event_q != '0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    fail_tally++;
  endtask

  always @(posedge clk) begin : track
    gpio_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) begin
        pin_function[i] = '0;
        pin_pull[i]     = '0;
      end
      latch_q   = '0;
      rise_en_q = '0;
      fall_en_q = '0;
      event_q   = '0;
      levels_q  = '0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_result(in_tuser, in_tdata[WORD_W-1:0],
            in_tdata[DATA_LSB +: DATA_W], in_tdata[PADS_LSB +: PADS_W]));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(out_tdata[DATA_W-1:0]), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.read_data)
            report_mismatch("read_data", 64'(out_tdata[DATA_W-1:0]), 64'(want.read_data));
          if (out_tdata[LEV_LSB +: PADS_W] !== want.drive_levels)
            report_mismatch("drive_levels", 64'(out_tdata[LEV_LSB +: PADS_W]),
                            64'(want.drive_levels));
          if (out_tdata[EN_LSB +: PADS_W] !== want.drive_enables)
            report_mismatch("drive_enables", 64'(out_tdata[EN_LSB +: PADS_W]),
                            64'(want.drive_enables));
          if (out_tdata[EP_BIT] !== want.event_pending)
            report_mismatch("event_pending", 64'(out_tdata[EP_BIT]), 64'(want.event_pending));
          if (out_tdata[OUT_TDATA_W-1:EP_BIT+1] !== '0)
            report_mismatch("spare bits", 64'(out_tdata[OUT_TDATA_W-1:EP_BIT+1]), '0);
        end
      end
    end
    due_q <= expected_results.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO edge detect core testbench
// Drives bus reads, writes and pad sample ticks into the core, first a short
// directed sequence and then a long random one, while the checker predicts
// and compares every result transfer.
// ----------------------------------------------------------------------------
module tb;
  import gpio_ed_pkg::*;

  localparam int N_RANDOM        = 1275;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 500;
  // Cycles without any transfer before the run is declared hung. The long
  // receiver hold-off is the worst correct case and sits well below this.
  localparam int STALL_LIMIT     = 2000;
  // Cycles allowed after the last result to catch any stray result.
  localparam int DRAIN_CYCLES    = 8;

  // The fourth operation code has no meaning and must change nothing.
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  // Word 6 lies in the gap after the function select words; the top word is
  // unmapped as well.
  localparam logic [WORD_W-1:0] W_HOLE    = W_FSEL5 + 6'd1;
  localparam logic [WORD_W-1:0] W_LAST    = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cycles = 0;
  // Pad levels carried by the most recent tick, so that new ticks can be
  // built as a few toggles away from the current pin state.
  logic [PADS_W-1:0] pad_state = '0;

  gpio_controller_edge_detect_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gpio_ed_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [PADS_W-1:0] rand_pads();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[PADS_W-1:0];
  endfunction

  // Picks a mapped register word, each register group about equally often.
  function automatic logic [WORD_W-1:0] pick_register();
    case ($urandom_range(0, 7))
      0:       return W_FSEL0 + WORD_W'($urandom_range(0, 5));
      1:       return $urandom_range(0, 1) ? W_SET1 : W_SET0;
      2:       return $urandom_range(0, 1) ? W_CLR1 : W_CLR0;
      3:       return $urandom_range(0, 1) ? W_LEV1 : W_LEV0;
      4:       return $urandom_range(0, 1) ? W_EDS1 : W_EDS0;
      5:       return $urandom_range(0, 1) ? W_REN1 : W_REN0;
      6:       return $urandom_range(0, 1) ? W_FEN1 : W_FEN0;
      default: return W_PULL0 + WORD_W'($urandom_range(0, 3));
    endcase
  endfunction

  // Offers one item and returns at the edge where its transfer happens. The
  // sender works in bursts; between bursts tvalid drops for a random gap, and
  // now and then there is no gap at all so that bursts run back to back.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] w,
                           input logic [DATA_W-1:0] d, input logic [PADS_W-1:0] pads);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pads, d, w};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
    if (op == OP_TICK) pad_state = pads;
  endtask

  // Receiver: stretches of random length, each with its own ready pattern
  // (always ready, coin toss, mostly stalled, or a regular one-in-three
  // stall). Once, part way into the random traffic, it holds off for a long
  // stretch so that the core fills both stages and drops in_tready while the
  // sender keeps offering.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit          held_off;
    held_off = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && items_sent >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((k % 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long
  // has hung, whatever the reason.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] w;
    logic [DATA_W-1:0] d;
    logic [PADS_W-1:0] pads;
    int unsigned       sel;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_READ;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset contents first, then every function select
    // extreme: the first word with its two spare top bits set, and the last
    // word whose upper fields belong to pins that do not exist.
    send_item(OP_READ,  W_FSEL0, '0, pad_state);
    send_item(OP_WRITE, W_FSEL0, 32'hC924_9249, pad_state);
    send_item(OP_WRITE, W_FSEL5, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_FSEL5, '0, pad_state);
    send_item(OP_WRITE, W_FSEL5, 32'h0924_9249, pad_state);
    // Set every latch bit in both banks, then clear the upper bank. The set
    // and clear words themselves always read back as zero.
    send_item(OP_WRITE, W_SET0, 32'hFFFF_FFFF, pad_state);
    send_item(OP_WRITE, W_SET1, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_SET1, '0, pad_state);
    send_item(OP_WRITE, W_CLR1, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_CLR0, '0, pad_state);
    // Rising edges on every pin, falling edges on the upper bank only.
    send_item(OP_WRITE, W_REN0, 32'hFFFF_FFFF, pad_state);
    send_item(OP_WRITE, W_REN1, 32'hFFFF_FFFF, pad_state);
    send_item(OP_WRITE, W_FEN1, 32'hFFFF_FFFF, pad_state);
    send_item(OP_TICK,  W_FSEL0, '0, '1);
    send_item(OP_READ,  W_EDS1, '0, pad_state);
    send_item(OP_TICK,  W_FSEL0, '0, '0);
    // Clearing the lower bank leaves the falling events of the upper one.
    send_item(OP_WRITE, W_EDS0, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_EDS0, '0, pad_state);
    // The level register is read only.
    send_item(OP_WRITE, W_LEV0, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_LEV0, '0, pad_state);
    // The last pull word only partly maps onto real pins.
    send_item(OP_WRITE, W_PULL3, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_PULL3, '0, pad_state);
    // Unmapped words and the meaningless operation change nothing.
    send_item(OP_WRITE, W_HOLE, 32'hFFFF_FFFF, pad_state);
    send_item(OP_READ,  W_LAST, '0, pad_state);
    send_item(OP_UNUSED, W_SET0, 32'hFFFF_FFFF, '1);

    // Random part: mostly well-formed register traffic and ticks that toggle
    // a few pins, with some raw noise on any word and operation.
    for (int n = 0; n < N_RANDOM; n++) begin
      sel  = $urandom_range(0, 99);
      w    = pick_register();
      d    = $urandom;
      pads = rand_pads();
      if (sel < 30) begin
        case ($urandom_range(0, 3))
          0, 1:    pads = pad_state ^ (rand_pads() & rand_pads() & rand_pads());
          2:       pads = pad_state ^ rand_pads();
          default: pads = ~pad_state;
        endcase
        send_item(OP_TICK, w, d, pads);
      end else if (sel < 60) begin
        // Function select writes make about half their pins outputs, and
        // event clears are sparse so that some events stay pending.
        if (w <= W_FSEL5) begin
          for (int k = 0; k < FSEL_PER_WORD; k++)
            if ($urandom_range(0, 1) != 0) d[3*k +: 3] = FSEL_OUT;
        end else if (w == W_EDS0 || w == W_EDS1) begin
          d = $urandom & $urandom;
        end
        send_item(OP_WRITE, w, d, pads);
      end else if (sel < 90) begin
        send_item(OP_READ, w, d, pads);
      end else if (sel < 97) begin
        send_item($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                  WORD_W'($urandom_range(0, 63)), d, pads);
      end else begin
        send_item(OP_UNUSED, w, d, pads);
      end
    end

    // Let the last results drain, then allow a little longer for anything
    // the core should not have produced.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/gpio_ed_pkg.sv
design/gpio_controller_edge_detect_core.sv
sim/gpio_ed_checker.sv
sim/tb.sv
